FILE: hw/rtl/rswt_pkg.sv
// Shared types and constants for the reliable send window tracker.
// Holds the transfer payload structs, status and opcode codes and the slot entry layout.
// Depends on nothing.
package rswt_pkg;

	// Opcodes of an input item.
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Result status codes.
	localparam logic [3:0] ST_SENT      = 4'd0;
	localparam logic [3:0] ST_ACK_ADV   = 4'd1;
	localparam logic [3:0] ST_ACK_IGN   = 4'd2;
	localparam logic [3:0] ST_DUP       = 4'd3;
	localparam logic [3:0] ST_FAST      = 4'd4;
	localparam logic [3:0] ST_TMO_RESND = 4'd5;
	localparam logic [3:0] ST_STALE     = 4'd6;
	localparam logic [3:0] ST_GIVE_UP   = 4'd7;
	localparam logic [3:0] ST_FULL      = 4'd8;

	// Configuration register indexes.
	localparam logic [1:0] REG_INITIAL_SEQ = 2'd0;
	localparam logic [1:0] REG_BASE_RTO    = 2'd1;
	localparam logic [1:0] REG_MAX_RTO     = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [31:0] INITIAL_SEQ_RST = 32'd0;
	localparam logic [15:0] BASE_RTO_RST    = 16'd100;
	localparam logic [15:0] MAX_RTO_RST     = 16'd6000;

	// Duplicate ack handling.
	localparam logic [2:0] DUP_LIMIT = 3'd3;
	localparam logic [2:0] DUP_SAT   = 3'd7;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] payload_len;
		logic [31:0] ack_num;
		logic [3:0]  slot;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] seq_num;
		logic [3:0]  out_slot;
		logic [15:0] timer_ticks;
		logic [31:0] acked_bytes;
		logic [4:0]  popped_count;
		logic        rtt_sample;
		logic        loss_event;
	} res_item_t;

	// One window slot as held in the slot memory.
	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] len;
		logic [15:0] rto;
		logic        resent;
	} slot_ent_t;

	// Operands of the shared subtractor.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	// Subtractor result with its flags.
	typedef struct packed {
		logic [31:0] diff;
		logic        zero;
	} alu_rsp_t;

endpackage

FILE: hw/rtl/rswt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the window slot store. Depends on nothing.
module rswt_ram #(
	parameter int WIDTH = 65,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/rswt_alu.sv
// Shared 32-bit subtractor of the window tracker sequencer.
// Depends on rswt_pkg for its request and response structs.
module rswt_alu (
	input  rswt_pkg::alu_req_t req,
	output rswt_pkg::alu_rsp_t rsp
);

	// Modular difference; all sequence range and distance checks use it.
	always_comb begin
		rsp.diff = req.a - req.b;
		rsp.zero = (rsp.diff == 32'd0);
	end

endmodule

FILE: hw/rtl/reliable_send_window_tracker.sv
// Top level of the reliable send window tracker: sequencer, window state and result register.
// Depends on rswt_pkg, rswt_ram and rswt_alu.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    rswt_pkg::in_item_t in_data
// out      output     out_valid / out_ready  rswt_pkg::res_item_t out_data
// cfg      input      cfg_valid / cfg_ready  cfg_index (2 bits), cfg_data (32 bits)
//
// Each item passes through decode and then the response step; an ack adds the range check,
// an advancing ack then releases slots one at a time, and a fast resend or a live timeout
// adds a step of its own. The slot memory read port and the one shared subtractor set these
// steps. in_ready is low meanwhile and returns in the cycle after the result register loads.
// A held result stalls the sequencer in its response step until out_ready takes it.
// Reset empties the window; the slot memory needs no clearing as only occupied slot data is used.
// Configuration writes are taken only while the sequencer is idle.
module reliable_send_window_tracker #(
	parameter int WINDOW_SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rswt_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rswt_pkg::res_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);
	localparam int ENT_W = $bits(rswt_pkg::slot_ent_t);
	localparam logic [IDX_W:0] SLOTS_W = (IDX_W + 1)'(WINDOW_SLOTS);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(WINDOW_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RANGE,
		S_POP,
		S_FAST,
		S_TMO,
		S_RESP
	} state_t;

	state_t state_q;

	// Configuration and window registers.
	logic [15:0]      base_rto_q;
	logic [15:0]      max_rto_q;
	logic [31:0]      last_sent_q;
	logic [31:0]      last_ack_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [2:0]       dup_q;

	// Latched item and working registers.
	rswt_pkg::in_item_t  item_q;
	rswt_pkg::res_item_t res_q;
	rswt_pkg::res_item_t out_q;
	logic                out_valid_q;
	logic [31:0]         dlo_q;
	logic                first_q;
	logic [CNT_W-1:0]    popped_q;

	// Slot memory ports.
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	rswt_pkg::slot_ent_t    ram_wdata;
	logic                   ram_re;
	logic [IDX_W-1:0]       ram_raddr;
	logic [ENT_W-1:0]       ram_rdata;
	rswt_pkg::slot_ent_t    ent;

	rswt_pkg::alu_req_t alu_req;
	rswt_pkg::alu_rsp_t alu_rsp;

	rswt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(WINDOW_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rswt_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign ent = rswt_pkg::slot_ent_t'(ram_rdata);

	// Index arithmetic on the circular slot queue.
	logic [IDX_W:0]   head_inc_w;
	logic [IDX_W-1:0] head_inc;
	logic [CNT_W:0]   tail_sum;
	logic [IDX_W-1:0] tail_idx;
	logic             slot_ok;
	logic [IDX_W-1:0] slot_idx;
	logic [IDX_W:0]   off_raw;
	logic [IDX_W:0]   off_w;
	logic             slot_live;
	logic [15:0]      len_eff;
	logic [2:0]       dup_n;
	logic             fully;
	logic [16:0]      rto_dbl;
	logic [15:0]      rto_new;

	always_comb begin
		head_inc_w = (IDX_W + 1)'(head_q) + (IDX_W + 1)'(1);
		if (head_inc_w >= SLOTS_W) begin
			head_inc_w = head_inc_w - SLOTS_W;
		end
		head_inc = head_inc_w[IDX_W-1:0];

		tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
		if (tail_sum >= (CNT_W + 1)'(WINDOW_SLOTS)) begin
			tail_sum = tail_sum - (CNT_W + 1)'(WINDOW_SLOTS);
		end
		tail_idx = tail_sum[IDX_W-1:0];

		slot_ok  = (32'(item_q.slot) < 32'(WINDOW_SLOTS));
		slot_idx = IDX_W'(item_q.slot);
		off_raw  = (IDX_W + 1)'(slot_idx) - (IDX_W + 1)'(head_q);
		off_w    = (slot_idx < head_q) ? (off_raw + SLOTS_W) : off_raw;
		slot_live = slot_ok && (off_w < (IDX_W + 1)'(count_q));

		len_eff = (item_q.payload_len == 16'd0) ? 16'd1 : item_q.payload_len;
		dup_n   = (dup_q < rswt_pkg::DUP_SAT) ? (dup_q + 3'd1) : dup_q;

		// Slot fully acked: distance from its start within half the space and past its end.
		fully = !alu_rsp.diff[31] && (alu_rsp.diff >= 32'(ent.len));

		rto_dbl = {ent.rto, 1'b0};
		rto_new = (rto_dbl < 17'(max_rto_q)) ? rto_dbl[15:0] : max_rto_q;
	end

	// Shared subtractor operand selection per sequencer step.
	always_comb begin
		case (state_q)
			S_DECODE: begin
				alu_req.a = item_q.ack_num;
				alu_req.b = last_ack_q;
			end
			S_RANGE: begin
				alu_req.a = last_sent_q + 32'd2;
				alu_req.b = last_ack_q;
			end
			default: begin
				alu_req.a = last_ack_q;
				alu_req.b = ent.seq;
			end
		endcase
	end

	// Slot memory read and write control.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = head_q;
		ram_we    = 1'b0;
		ram_waddr = tail_idx;
		ram_wdata = '{seq: last_sent_q + 32'd1, len: len_eff, rto: base_rto_q, resent: 1'b0};
		case (state_q)
			S_DECODE: begin
				if (item_q.opcode == rswt_pkg::OP_SEND) begin
					ram_we = (count_q < SLOTS_C);
				end else if (item_q.opcode == rswt_pkg::OP_TIMEOUT) begin
					ram_re    = slot_live;
					ram_raddr = slot_idx;
				end
			end
			S_RANGE: begin
				ram_re = 1'b1;
			end
			S_POP: begin
				ram_re    = fully;
				ram_raddr = head_inc;
			end
			S_FAST: begin
				ram_we    = 1'b1;
				ram_waddr = head_q;
				ram_wdata = '{seq: ent.seq, len: ent.len, rto: rto_new, resent: 1'b1};
			end
			S_TMO: begin
				ram_we    = !fully && (ent.rto < max_rto_q);
				ram_waddr = slot_idx;
				ram_wdata = '{seq: ent.seq, len: ent.len, rto: rto_new, resent: 1'b1};
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Sequencer, window state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_rto_q  <= rswt_pkg::BASE_RTO_RST;
			max_rto_q   <= rswt_pkg::MAX_RTO_RST;
			last_sent_q <= rswt_pkg::INITIAL_SEQ_RST;
			last_ack_q  <= rswt_pkg::INITIAL_SEQ_RST + 32'd1;
			head_q      <= '0;
			count_q     <= '0;
			dup_q       <= '0;
			item_q      <= '0;
			res_q       <= '0;
			out_q       <= '0;
			dlo_q       <= '0;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
			popped_q    <= '0;
		end else begin
			// The result register fills from the response step and empties on a transfer.
			if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// Register writes from the configuration port.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rswt_pkg::REG_INITIAL_SEQ: begin
						last_sent_q <= cfg_data;
						last_ack_q  <= cfg_data + 32'd1;
						head_q      <= '0;
						count_q     <= '0;
						dup_q       <= '0;
					end
					rswt_pkg::REG_BASE_RTO: begin
						base_rto_q <= cfg_data[15:0];
					end
					rswt_pkg::REG_MAX_RTO: begin
						max_rto_q <= cfg_data[15:0];
					end
					default: begin
						base_rto_q <= base_rto_q;
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_data;
						res_q   <= '0;
						state_q <= S_DECODE;
					end
				end

				S_DECODE: begin
					case (item_q.opcode)
						rswt_pkg::OP_SEND: begin
							state_q <= S_RESP;
							if (count_q < SLOTS_C) begin
								count_q           <= count_q + CNT_W'(1);
								last_sent_q       <= last_sent_q + 32'(len_eff);
								res_q.status      <= rswt_pkg::ST_SENT;
								res_q.seq_num     <= last_sent_q + 32'd1;
								res_q.out_slot    <= 4'(tail_idx);
								res_q.timer_ticks <= base_rto_q;
							end else begin
								res_q.status <= rswt_pkg::ST_FULL;
							end
						end
						rswt_pkg::OP_ACK: begin
							dlo_q   <= alu_rsp.diff;
							state_q <= S_RANGE;
						end
						rswt_pkg::OP_TIMEOUT: begin
							res_q.status <= rswt_pkg::ST_STALE;
							state_q      <= slot_live ? S_TMO : S_RESP;
						end
						default: begin
							res_q.status <= rswt_pkg::ST_ACK_IGN;
							state_q      <= S_RESP;
						end
					endcase
				end

				// Range check from the last ack, then ignore, duplicate or advance.
				S_RANGE: begin
					if (!(dlo_q < alu_rsp.diff)) begin
						res_q.status <= rswt_pkg::ST_ACK_IGN;
						state_q      <= S_RESP;
					end else if (dlo_q == 32'd0) begin
						dup_q        <= dup_n;
						res_q.status <= rswt_pkg::ST_DUP;
						if (dup_n == rswt_pkg::DUP_LIMIT && count_q != '0) begin
							state_q <= S_FAST;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						dup_q             <= '0;
						last_ack_q        <= item_q.ack_num;
						res_q.status      <= rswt_pkg::ST_ACK_ADV;
						res_q.acked_bytes <= dlo_q;
						popped_q          <= '0;
						first_q           <= 1'b1;
						state_q           <= (count_q != '0) ? S_POP : S_RESP;
					end
				end

				// Release fully acked slots from the head, one per cycle.
				S_POP: begin
					first_q <= 1'b0;
					if (first_q) begin
						res_q.rtt_sample <= !ent.resent;
					end
					// The first popped slot is reported; with nothing popped it stays zero.
					if (first_q && fully) begin
						res_q.out_slot <= 4'(head_q);
					end
					if (fully) begin
						head_q   <= head_inc;
						count_q  <= count_q - CNT_W'(1);
						popped_q <= popped_q + CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							res_q.popped_count <= 5'(popped_q + CNT_W'(1));
							state_q            <= S_RESP;
						end
					end else begin
						res_q.popped_count <= 5'(popped_q);
						state_q            <= S_RESP;
					end
				end

				S_FAST: begin
					res_q.status      <= rswt_pkg::ST_FAST;
					res_q.seq_num     <= ent.seq;
					res_q.out_slot    <= 4'(head_q);
					res_q.timer_ticks <= rto_new;
					state_q           <= S_RESP;
				end

				S_TMO: begin
					state_q <= S_RESP;
					if (!fully) begin
						res_q.seq_num  <= ent.seq;
						res_q.out_slot <= 4'(slot_idx);
						if (ent.rto >= max_rto_q) begin
							res_q.status <= rswt_pkg::ST_GIVE_UP;
						end else begin
							res_q.status      <= rswt_pkg::ST_TMO_RESND;
							res_q.loss_event  <= (ent.seq == last_ack_q);
							res_q.timer_ticks <= rto_new;
						end
					end
				end

				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The window never holds more slots than it has.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= WINDOW_SLOTS)
		else $error("slot count exceeds window size");

	// An accepted item blocks the input until it is finished.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted transfer");

	// Slot memory is only written while an item is in work.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != S_IDLE && state_q != S_RESP)
		else $error("slot memory written outside item processing");

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the reliable send window tracker: directed table, then random traffic.
// Holds its own window predictor and compares every result transfer in full against it.
// Depends on rswt_pkg and the reliable_send_window_tracker RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rswt_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rswt_pkg::res_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	reliable_send_window_tracker #(.WINDOW_SLOTS(SLOTS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor copy of the window state and configuration.
	logic [31:0] w_init_seq;
	logic [15:0] w_base_rto, w_max_rto;
	logic [31:0] w_seq [SLOTS];
	logic [15:0] w_len [SLOTS];
	logic [15:0] w_rto [SLOTS];
	logic w_resent [SLOTS];
	logic [3:0] w_head;
	logic [4:0] w_count;
	logic [31:0] w_last_sent, w_last_ack;
	logic [2:0] w_dups;

	rswt_pkg::res_item_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int items_sent = 0;
	int status_hits[9];
	bit hold_off = 1'b0;

	function automatic bit seg_acked(logic [31:0] seq, logic [15:0] len, logic [31:0] ack);
		logic [31:0] delta;
		delta = ack - seq;
		return delta <= 32'h7FFF_FFFF && delta >= {16'd0, len};
	endfunction

	function automatic logic [15:0] backoff(logic [15:0] rto);
		logic [16:0] d;
		d = {rto, 1'b0};
		return (d < {1'b0, w_max_rto}) ? d[15:0] : w_max_rto;
	endfunction

	function automatic void window_load();
		w_last_sent = w_init_seq;
		w_last_ack = w_init_seq + 32'd1;
		w_head = '0;
		w_count = '0;
		w_dups = '0;
	endfunction

	// Apply one item to the predicted window and return the expected result.
	function automatic rswt_pkg::res_item_t window_step(rswt_pkg::in_item_t it);
		rswt_pkg::res_item_t r;
		logic [3:0] t;
		logic [15:0] len;
		logic [31:0] hi;
		bit in_rng;
		logic [4:0] off;
		r = '0;
		r.status = rswt_pkg::ST_ACK_IGN;
		case (it.opcode)
			rswt_pkg::OP_SEND: begin
				if (w_count >= SLOTS) begin
					r.status = rswt_pkg::ST_FULL;
				end else begin
					t = w_head + w_count[3:0];
					len = (it.payload_len == 16'd0) ? 16'd1 : it.payload_len;
					w_seq[t] = w_last_sent + 32'd1;
					w_len[t] = len;
					w_rto[t] = w_base_rto;
					w_resent[t] = 1'b0;
					w_count++;
					w_last_sent += {16'd0, len};
					r.status = rswt_pkg::ST_SENT;
					r.seq_num = w_seq[t];
					r.out_slot = t;
					r.timer_ticks = w_base_rto;
				end
			end
			rswt_pkg::OP_ACK: begin
				hi = w_last_sent + 32'd2;
				if (w_last_ack <= hi) in_rng = it.ack_num >= w_last_ack && it.ack_num < hi;
				else in_rng = !(it.ack_num >= hi && it.ack_num < w_last_ack);
				if (!in_rng) begin
					r.status = rswt_pkg::ST_ACK_IGN;
				end else if (it.ack_num == w_last_ack) begin
					if (w_dups < rswt_pkg::DUP_SAT) w_dups++;
					r.status = rswt_pkg::ST_DUP;
					if (w_dups == rswt_pkg::DUP_LIMIT && w_count > 0) begin
						w_rto[w_head] = backoff(w_rto[w_head]);
						w_resent[w_head] = 1'b1;
						r.status = rswt_pkg::ST_FAST;
						r.seq_num = w_seq[w_head];
						r.out_slot = w_head;
						r.timer_ticks = w_rto[w_head];
					end
				end else begin
					w_dups = '0;
					r.status = rswt_pkg::ST_ACK_ADV;
					r.acked_bytes = it.ack_num - w_last_ack;
					w_last_ack = it.ack_num;
					if (w_count > 0) begin
						r.rtt_sample = !w_resent[w_head];
						r.out_slot = w_head;
					end
					while (w_count > 0 && seg_acked(w_seq[w_head], w_len[w_head], w_last_ack)) begin
						w_head++;
						w_count--;
						r.popped_count++;
					end
					if (r.popped_count == 0) r.out_slot = '0;
				end
			end
			rswt_pkg::OP_TIMEOUT: begin
				r.status = rswt_pkg::ST_STALE;
				off = {1'b0, it.slot - w_head};
				if (off < w_count && !seg_acked(w_seq[it.slot], w_len[it.slot], w_last_ack)) begin
					r.seq_num = w_seq[it.slot];
					r.out_slot = it.slot;
					if (w_rto[it.slot] >= w_max_rto) begin
						r.status = rswt_pkg::ST_GIVE_UP;
					end else begin
						r.loss_event = (w_seq[it.slot] == w_last_ack);
						w_rto[it.slot] = backoff(w_rto[it.slot]);
						w_resent[it.slot] = 1'b1;
						r.status = rswt_pkg::ST_TMO_RESND;
						r.timer_ticks = w_rto[it.slot];
					end
				end
			end
			default: r.status = rswt_pkg::ST_ACK_IGN;
		endcase
		return r;
	endfunction

	// Watchdog on cycles without any transfer.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stalls, long hold-offs while requested, and the check.
	initial begin
		int gap;
		rswt_pkg::res_item_t exp_r;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", out_data);
				end else begin
					exp_r = pending_results.pop_front();
					if (exp_r.status <= rswt_pkg::ST_FULL) status_hits[exp_r.status]++;
					if (out_data !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p, got %p", exp_r, out_data);
					end
				end
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
				if (hold_off) gap = 300;
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(posedge clk);
					out_ready <= 1'b1;
				end
			end else if (!out_ready) begin
				out_ready <= 1'b1;
			end
		end
	end

	// The task waits on the clock after the previous transfer, so valid drops before it rises again.
	task automatic send_item(rswt_pkg::in_item_t it, int gap);
		@(posedge clk);
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		pending_results.push_back(window_step(it));
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		items_sent++;
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			rswt_pkg::REG_INITIAL_SEQ: begin
				w_init_seq = val;
				window_load();
			end
			rswt_pkg::REG_BASE_RTO: w_base_rto = val[15:0];
			rswt_pkg::REG_MAX_RTO: w_max_rto = val[15:0];
			default: ;
		endcase
	endtask

	function automatic rswt_pkg::in_item_t mk(logic [1:0] op, logic [15:0] len,
			logic [31:0] ack, logic [3:0] s);
		rswt_pkg::in_item_t it;
		it.opcode = op;
		it.payload_len = len;
		it.ack_num = ack;
		it.slot = s;
		return it;
	endfunction

	// Random item; its acks are biased toward the live window.
	function automatic rswt_pkg::in_item_t rand_item();
		int pick;
		logic [31:0] span;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return mk(rswt_pkg::OP_SEND, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
				16'($urandom_range(0, 40)), $urandom, 4'($urandom));
		if (pick < 75) begin
			span = w_last_sent + 32'd2 - w_last_ack;
			if ($urandom_range(0, 3) == 0)
				return mk(rswt_pkg::OP_ACK, 16'($urandom), w_last_ack, 4'($urandom));
			if ($urandom_range(0, 9) == 0)
				return mk(rswt_pkg::OP_ACK, 16'($urandom), $urandom, 4'($urandom));
			return mk(rswt_pkg::OP_ACK, 16'($urandom), w_last_ack + (span == 0 ? 32'd0 :
				32'($urandom_range(0, (span > 200) ? 200 : span - 1))), 4'($urandom));
		end
		if (pick < 97)
			return mk(rswt_pkg::OP_TIMEOUT, 16'($urandom), $urandom, 4'($urandom));
		return mk(2'd3, 16'($urandom), $urandom, 4'($urandom));
	endfunction

	typedef struct {
		rswt_pkg::in_item_t it;
		bit known;
		rswt_pkg::res_item_t res;
	} stim_row_t;

	initial begin
		stim_row_t rows[$];
		rswt_pkg::res_item_t exp_r;
		int phase;
		w_init_seq = rswt_pkg::INITIAL_SEQ_RST;
		w_base_rto = rswt_pkg::BASE_RTO_RST;
		w_max_rto = rswt_pkg::MAX_RTO_RST;
		window_load();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; a typed result is checked against the predictor as well.
		exp_r = '0; exp_r.status = rswt_pkg::ST_SENT; exp_r.seq_num = 32'd1;
		exp_r.timer_ticks = 16'd100;
		rows.push_back('{mk(rswt_pkg::OP_SEND, 16'd0, 32'd0, 4'd0), 1, exp_r});
		exp_r = '0; exp_r.status = rswt_pkg::ST_STALE;
		rows.push_back('{mk(rswt_pkg::OP_TIMEOUT, 16'd0, 32'd0, 4'd15), 1, exp_r});
		exp_r = '0; exp_r.status = rswt_pkg::ST_ACK_IGN;
		rows.push_back('{mk(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 4'd15), 1, exp_r});
		rows.push_back('{mk(rswt_pkg::OP_ACK, 16'd0, 32'hFFFF_FFFF, 4'd0), 1, exp_r});
		rows.push_back('{mk(rswt_pkg::OP_SEND, 16'hFFFF, 32'd0, 4'd0), 0, exp_r});
		for (int i = 0; i < 4; i++)
			rows.push_back('{mk(rswt_pkg::OP_ACK, 16'd0, 32'd1, 4'd0), 0, exp_r});
		rows.push_back('{mk(rswt_pkg::OP_TIMEOUT, 16'd0, 32'd0, 4'd1), 0, exp_r});
		rows.push_back('{mk(rswt_pkg::OP_ACK, 16'd0, 32'd2, 4'd0), 0, exp_r});
		rows.push_back('{mk(rswt_pkg::OP_ACK, 16'd0, 32'h1_0001, 4'd0), 0, exp_r});
		for (int i = 0; i < 17; i++)
			rows.push_back('{mk(rswt_pkg::OP_SEND, 16'd3, 32'd0, 4'd0), 0, exp_r});
		foreach (rows[i]) begin
			send_item(rows[i].it, $urandom_range(0, 2));
			if (rows[i].known && pending_results[$] !== rows[i].res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: expected %p, predicted %p", i, rows[i].res,
						pending_results[$]);
			end
		end
		drain();

		// Random phases over several settings, extremes included.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(rswt_pkg::REG_INITIAL_SEQ, 32'hFFFF_FFF0);
					write_reg(rswt_pkg::REG_BASE_RTO, 32'd1);
					write_reg(rswt_pkg::REG_MAX_RTO, 32'h0000_FFFF); end
				1: begin write_reg(rswt_pkg::REG_INITIAL_SEQ, 32'h7FFF_FFFF);
					write_reg(rswt_pkg::REG_BASE_RTO, 32'h0000_FFFF);
					write_reg(rswt_pkg::REG_MAX_RTO, 32'd1); end
				2: begin write_reg(rswt_pkg::REG_INITIAL_SEQ, 32'd0);
					write_reg(rswt_pkg::REG_BASE_RTO, 32'd5);
					write_reg(rswt_pkg::REG_MAX_RTO, 32'd40); end
				default: begin write_reg(rswt_pkg::REG_INITIAL_SEQ, $urandom);
					write_reg(rswt_pkg::REG_BASE_RTO, 32'($urandom_range(1, 65535)));
					write_reg(rswt_pkg::REG_MAX_RTO, 32'($urandom_range(1, 65535))); end
			endcase
			if (phase == 1) hold_off = 1'b1;
			for (int k = 0; k < 85; k++) begin
				if (phase == 1 && k == 20) hold_off = 1'b0;
				send_item(rand_item(), ($urandom_range(0, 3) == 0) ? 0 :
					$urandom_range(0, 14));
				if (k == 50) while (pending_results.size() != 0) @(posedge clk);
			end
			drain();
		end

		$display("Sent %0d items, checked %0d results; status counts sent/adv/ign/dup/fast/",
			items_sent, results_seen);
		$display("  resend/stale/giveup/full = %p", status_hits);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
